>>> rtl/core/s2c_pkg.sv
// shared constants, types and helpers for the spherical to cartesian converter
`default_nettype none

package s2c_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int FRAC_BITS     = 14;
  localparam int CORDIC_STAGES = 16;

  localparam int ATAN_ENTRIES = 24;
  localparam int STAGES_USED  = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  localparam int RADIUS_W   = FRAC_BITS + 2;
  localparam int OUT_W      = FRAC_BITS + 4;
  localparam int UNIT_SHIFT = 30;
  localparam int GAIN_START = 652032874;

  // rotator datapath widths
  localparam int XY_W = 34;
  localparam int Z_W  = 33;
  localparam int CS_W = 32;
  localparam int RC_W = 32;

  // pipeline depth: decode, rotations, quadrant, two multiply stages, output
  localparam int ROT_LAT = STAGES_USED + 2;
  localparam int NSTG    = ROT_LAT + 3;

  localparam int IN_TDATA_W  = ((RADIUS_W + 2 * ANGLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((3 * OUT_W + 7) / 8) * 8;

  localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
  localparam logic signed [63:0] OUT_MIN = -OUT_MAX - 64'sd1;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic [NSTG-1:0] en;
    logic [NSTG-1:0] vld;
  } flow_ctl_t;

  function automatic logic [OUT_W-1:0] sat_out(input logic signed [63:0] v);
    logic [OUT_W-1:0] res;
    if (v > OUT_MAX) begin
      res = OUT_MAX[OUT_W-1:0];
    end else if (v < OUT_MIN) begin
      res = OUT_MIN[OUT_W-1:0];
    end else begin
      res = v[OUT_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/spherical_to_cartesian.sv
// top level of the spherical to cartesian converter
`default_nettype none

// Converts (radius, azimuth, elevation) into x, y and z, one request per clock
// cycle while output back-pressure has not filled the pipeline. The latency is
// set by the unrolled cordic rotators, one rotation per register stage, followed
// by the quadrant stage, two multiply stages and the output register. Angles are
// binary angles with 2^ANGLE_BITS units per turn; radius and outputs carry
// FRAC_BITS fractional bits and outputs are rounded to nearest. Back-pressure on
// the output only stalls stages that hold data, so bubbles are absorbed.
module spherical_to_cartesian import s2c_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // radius, azimuth, elevation
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // x_coord, y_coord, z_coord, zero pad
);

  flow_ctl_t ctl;

  logic [RADIUS_W-1:0]    radius;
  logic [ANGLE_BITS-1:0]  azimuth;
  logic [ANGLE_BITS-1:0]  elevation;
  logic [RADIUS_W-1:0]    rad_r [ROT_LAT];
  logic signed [CS_W-1:0] cos_az;
  logic signed [CS_W-1:0] sin_az;
  logic signed [CS_W-1:0] cos_el;
  logic signed [CS_W-1:0] sin_el;
  logic [OUT_W-1:0]       x_coord;
  logic [OUT_W-1:0]       y_coord;
  logic [OUT_W-1:0]       z_coord;

  assign radius    = in_tdata[RADIUS_W-1:0];
  assign azimuth   = in_tdata[RADIUS_W +: ANGLE_BITS];
  assign elevation = in_tdata[RADIUS_W + ANGLE_BITS +: ANGLE_BITS];

  s2c_flow u_flow (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .ctl       (ctl)
  );

  s2c_rotator u_rot_az (
    .clk     (clk),
    .en      (ctl.en[ROT_LAT-1:0]),
    .ang     (azimuth),
    .cos_out (cos_az),
    .sin_out (sin_az)
  );

  s2c_rotator u_rot_el (
    .clk     (clk),
    .en      (ctl.en[ROT_LAT-1:0]),
    .ang     (elevation),
    .cos_out (cos_el),
    .sin_out (sin_el)
  );

  // radius rides alongside the rotators
  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      rad_r[0] <= radius;
    end
  end

  for (genvar k = 1; k < ROT_LAT; k++) begin : g_rad
    always_ff @(posedge clk) begin
      if (ctl.en[k]) begin
        rad_r[k] <= rad_r[k-1];
      end
    end
  end

  s2c_scale u_scale (
    .clk     (clk),
    .en      (ctl.en[NSTG-1 -: 3]),
    .radius  (rad_r[ROT_LAT-1]),
    .cos_az  (cos_az),
    .sin_az  (sin_az),
    .cos_el  (cos_el),
    .sin_el  (sin_el),
    .x_coord (x_coord),
    .y_coord (y_coord),
    .z_coord (z_coord)
  );

  assign out_tvalid = ctl.vld[NSTG-1];
  assign out_tdata  = OUT_TDATA_W'({z_coord, y_coord, x_coord});

  // input only stalls when every stage is full and the output is held
  a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while the pipeline has room");

  a_count_up : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !(out_tvalid && out_tready)) |=>
      ($countones(ctl.vld) == $past($countones(ctl.vld)) + 1))
    else $error("accepted request not tracked in pipeline");

  a_count_down : assert property (@(posedge clk) disable iff (!rst_n)
    (!(in_tvalid && in_tready) && out_tvalid && out_tready) |=>
      ($countones(ctl.vld) + 1 == $past($countones(ctl.vld))))
    else $error("delivered result not removed from pipeline");

endmodule

`default_nettype wire

>>> rtl/core/s2c_flow.sv
// valid and load-enable chain for the converter pipeline
`default_nettype none

module s2c_flow import s2c_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output flow_ctl_t ctl
);

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG:0]   rdy;

  // a stage loads when it is empty or its contents move on
  always_comb begin
    rdy[NSTG] = out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt = vld_r;
    for (int k = 0; k < NSTG; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready = rdy[0];
  assign ctl.en   = rdy[NSTG-1:0];
  assign ctl.vld  = vld_r;

endmodule

`default_nettype wire

>>> rtl/core/s2c_rotator.sv
// pipelined cordic rotator giving cosine and sine of a binary angle
`default_nettype none

module s2c_rotator import s2c_pkg::*; (
  input  logic                   clk,
  input  logic [ROT_LAT-1:0]     en,
  input  logic [ANGLE_BITS-1:0]  ang,
  output logic signed [CS_W-1:0] cos_out,
  output logic signed [CS_W-1:0] sin_out
);

  localparam logic signed [XY_W-1:0] UNIT_ONE = XY_W'(1) <<< UNIT_SHIFT;

  logic signed [XY_W-1:0] x_r   [STAGES_USED+1];
  logic signed [XY_W-1:0] y_r   [STAGES_USED+1];
  logic signed [Z_W-1:0]  z_r   [STAGES_USED+1];
  logic [1:0]             q_r   [STAGES_USED+1];
  logic                   byp_r [STAGES_USED+1];

  logic signed [XY_W-1:0] cb;
  logic signed [XY_W-1:0] sb;
  logic signed [XY_W-1:0] co;
  logic signed [XY_W-1:0] si;
  logic signed [CS_W-1:0] cos_r;
  logic signed [CS_W-1:0] sin_r;

  // split into quadrant and residual, residual of zero bypasses the rotation results
  always_ff @(posedge clk) begin
    if (en[0]) begin
      q_r[0]   <= ang[ANGLE_BITS-1 -: 2];
      byp_r[0] <= (ang[ANGLE_BITS-3:0] == '0);
      x_r[0]   <= XY_W'(GAIN_START);
      y_r[0]   <= '0;
      z_r[0]   <= Z_W'({ang[ANGLE_BITS-3:0], {(32 - ANGLE_BITS){1'b0}}});
    end
  end

  for (genvar i = 1; i <= STAGES_USED; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en[i]) begin
        q_r[i]   <= q_r[i-1];
        byp_r[i] <= byp_r[i-1];
        if (!z_r[i-1][Z_W-1]) begin
          x_r[i] <= x_r[i-1] - (y_r[i-1] >>> (i - 1));
          y_r[i] <= y_r[i-1] + (x_r[i-1] >>> (i - 1));
          z_r[i] <= z_r[i-1] - $signed(Z_W'(ATAN_TAB[i-1]));
        end else begin
          x_r[i] <= x_r[i-1] + (y_r[i-1] >>> (i - 1));
          y_r[i] <= y_r[i-1] - (x_r[i-1] >>> (i - 1));
          z_r[i] <= z_r[i-1] + $signed(Z_W'(ATAN_TAB[i-1]));
        end
      end
    end
  end

  // quadrant rotation by multiples of a quarter turn
  always_comb begin
    cb = byp_r[STAGES_USED] ? UNIT_ONE : x_r[STAGES_USED];
    sb = byp_r[STAGES_USED] ? '0 : y_r[STAGES_USED];
    unique case (q_r[STAGES_USED])
      2'd0: begin
        co = cb;
        si = sb;
      end
      2'd1: begin
        co = -sb;
        si = cb;
      end
      2'd2: begin
        co = -cb;
        si = -sb;
      end
      default: begin
        co = sb;
        si = -cb;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[ROT_LAT-1]) begin
      cos_r <= CS_W'(co);
      sin_r <= CS_W'(si);
    end
  end

  assign cos_out = cos_r;
  assign sin_out = sin_r;

endmodule

`default_nettype wire

>>> rtl/core/s2c_scale.sv
// radius scaling: two multiply stages and the rounded, saturated output register
`default_nettype none

module s2c_scale import s2c_pkg::*; (
  input  logic                   clk,
  input  logic [2:0]             en,
  input  logic [RADIUS_W-1:0]    radius,
  input  logic signed [CS_W-1:0] cos_az,
  input  logic signed [CS_W-1:0] sin_az,
  input  logic signed [CS_W-1:0] cos_el,
  input  logic signed [CS_W-1:0] sin_el,
  output logic [OUT_W-1:0]       x_coord,
  output logic [OUT_W-1:0]       y_coord,
  output logic [OUT_W-1:0]       z_coord
);

  localparam int PE_W = RADIUS_W + CS_W + 1;
  localparam int PX_W = RC_W + CS_W;
  localparam int XY_SHIFT = 2 * UNIT_SHIFT - RADIUS_W;
  localparam logic signed [PE_W-1:0] RND_E = PE_W'(1) <<< (RADIUS_W - 1);
  localparam logic signed [PE_W-1:0] RND_Z = PE_W'(1) <<< (UNIT_SHIFT - 1);
  localparam logic signed [PX_W-1:0] RND_X = PX_W'(1) <<< (XY_SHIFT - 1);

  logic signed [PE_W-1:0] pe;
  logic signed [PE_W-1:0] pz;
  logic signed [PE_W-1:0] pe_rnd;
  logic signed [PE_W-1:0] pz_rnd;
  logic signed [PX_W-1:0] px_rnd;
  logic signed [PX_W-1:0] py_rnd;

  logic signed [RC_W-1:0] rc_r;
  logic signed [CS_W-1:0] ca_r;
  logic signed [CS_W-1:0] sa_r;
  logic [OUT_W-1:0]       z1_r;
  logic signed [PX_W-1:0] px_r;
  logic signed [PX_W-1:0] py_r;
  logic [OUT_W-1:0]       z2_r;
  logic [OUT_W-1:0]       x_r;
  logic [OUT_W-1:0]       y_r;
  logic [OUT_W-1:0]       z_r;

  // r * cos(el) and r * sin(el)
  always_comb begin
    pe     = $signed({1'b0, radius}) * cos_el;
    pz     = $signed({1'b0, radius}) * sin_el;
    pe_rnd = (pe + RND_E) >>> RADIUS_W;
    pz_rnd = (pz + RND_Z) >>> UNIT_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rc_r <= RC_W'(pe_rnd);
      z1_r <= sat_out(64'(pz_rnd));
      ca_r <= cos_az;
      sa_r <= sin_az;
    end
  end

  // scaled horizontal length times cos and sin of azimuth
  always_ff @(posedge clk) begin
    if (en[1]) begin
      px_r <= rc_r * ca_r;
      py_r <= rc_r * sa_r;
      z2_r <= z1_r;
    end
  end

  always_comb begin
    px_rnd = (px_r + RND_X) >>> XY_SHIFT;
    py_rnd = (py_r + RND_X) >>> XY_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      x_r <= sat_out(64'(px_rnd));
      y_r <= sat_out(64'(py_rnd));
      z_r <= z2_r;
    end
  end

  assign x_coord = x_r;
  assign y_coord = y_r;
  assign z_coord = z_r;

endmodule

`default_nettype wire

>>> tb/sv/coord_checker.sv
// checker for the spherical to cartesian converter: predicts each result and compares it
module coord_checker import s2c_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     fault_count,
  output int                     pending_count
);

  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } coords_t;

  coords_t coords_due[$];
  int      faults = 0;
  int      due_count = 0;

  assign fault_count   = faults;
  assign pending_count = due_count;

  // round to nearest, ties toward plus infinity
  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_out(input longint v);
    longint hi_val;
    longint lo_val;
    hi_val = (longint'(1) <<< (OUT_W - 1)) - 1;
    lo_val = -hi_val - 1;
    if (v > hi_val) begin
      v = hi_val;
    end else if (v < lo_val) begin
      v = lo_val;
    end
    return OUT_W'(v);
  endfunction

  // cosine and sine of a binary angle, scaled by 2^30
  function automatic void unit_vector(input logic [ANGLE_BITS-1:0] ang,
                                      output longint cs, output longint sn);
    logic [1:0]            quad;
    logic [ANGLE_BITS-3:0] resid;
    longint                vx, vy, vz, nx;
    quad  = ang[ANGLE_BITS-1 -: 2];
    resid = ang[ANGLE_BITS-3:0];
    if (resid == '0) begin
      vx = longint'(1) <<< UNIT_SHIFT;
      vy = 0;
    end else begin
      vx = GAIN_START;
      vy = 0;
      vz = longint'(resid) <<< (32 - ANGLE_BITS);
      for (int i = 0; i < STAGES_USED; i++) begin
        if (vz >= 0) begin
          nx = vx - (vy >>> i);
          vy = vy + (vx >>> i);
          vz = vz - longint'(ATAN_TAB[i]);
        end else begin
          nx = vx + (vy >>> i);
          vy = vy - (vx >>> i);
          vz = vz + longint'(ATAN_TAB[i]);
        end
        vx = nx;
      end
    end
    case (quad)
      2'd0: begin
        cs = vx;
        sn = vy;
      end
      2'd1: begin
        cs = -vy;
        sn = vx;
      end
      2'd2: begin
        cs = -vx;
        sn = -vy;
      end
      default: begin
        cs = vy;
        sn = -vx;
      end
    endcase
  endfunction

  function automatic coords_t convert_position(input logic [RADIUS_W-1:0] radius,
                                               input logic [ANGLE_BITS-1:0] azimuth,
                                               input logic [ANGLE_BITS-1:0] elevation);
    longint  ca, sa, ce, se, r, rc;
    coords_t c;
    unit_vector(azimuth, ca, sa);
    unit_vector(elevation, ce, se);
    r    = longint'(radius);
    rc   = round_shift(r * ce, RADIUS_W);
    c.x  = clamp_out(round_shift(rc * ca, 2 * UNIT_SHIFT - RADIUS_W));
    c.y  = clamp_out(round_shift(rc * sa, 2 * UNIT_SHIFT - RADIUS_W));
    c.z  = clamp_out(round_shift(r * se, UNIT_SHIFT));
    return c;
  endfunction

  always @(posedge clk) begin
    coords_t got;
    coords_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.x = out_tdata[OUT_W-1:0];
        got.y = out_tdata[2*OUT_W-1:OUT_W];
        got.z = out_tdata[3*OUT_W-1:2*OUT_W];
        if (coords_due.size() == 0) begin
          if (faults < REPORT_LIMIT) begin
            $display("unexpected result x=%0d y=%0d z=%0d", got.x, got.y, got.z);
          end
          faults++;
        end else begin
          want = coords_due.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
            if (faults < REPORT_LIMIT) begin
              $display("mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                       want.x, want.y, want.z, got.x, got.y, got.z);
            end
            faults++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        coords_due.push_back(convert_position(
          in_tdata[RADIUS_W-1:0],
          in_tdata[RADIUS_W +: ANGLE_BITS],
          in_tdata[RADIUS_W+ANGLE_BITS +: ANGLE_BITS]));
      end
    end
    due_count <= coords_due.size();
  end

endmodule

>>> tb/sv/testbench.sv
// testbench top: drives position requests into the converter and gives the verdict
module testbench;
  import s2c_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 550;
  localparam int PHASE_LEN    = 70;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int                     mismatch_count;
  int                     pending_count;
  int                     send_idle_pct = 0;
  int                     stall_pct = 0;

  spherical_to_cartesian dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  coord_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fault_count   (mismatch_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_position(input logic [15:0] radius,
                               input logic signed [15:0] az,
                               input logic signed [15:0] el);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({el, az, radius});
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    logic [15:0]        rad;
    logic signed [15:0] az;
    logic signed [15:0] el;
    int                 phase;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_position(16'd0, 0, 0);
    send_position(16'd65535, 0, 0);
    send_position(16'd65535, 16384, 0);
    send_position(16'd65535, -32768, 0);
    send_position(16'd65535, -16384, 0);
    send_position(16'd65535, 32767, 0);
    send_position(16'd65535, 8192, 8192);
    // poles
    send_position(16'd65535, 1234, 16384);
    send_position(16'd65535, -5000, -16384);
    send_position(16'd16384, 0, 16384);
    send_position(16'd16384, 1, 1);
    send_position(16'd16384, -1, -1);
    send_position(16'd40000, 12345, -12345);
    // going on over a pole
    send_position(16'd65535, 24576, 20000);
    send_position(16'd65535, -8192, -20000);
    send_position(16'd1, 5461, 5461);
    send_position(16'd32768, 16383, 16383);
    send_position(16'd65535, -16385, 16383);
    send_position(16'd21845, 10923, -8191);
    send_position(16'd65535, -32767, -16383);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        phase = (n / PHASE_LEN) % 4;
        case (phase)
          0: begin
            send_idle_pct = 0;
            stall_pct    <= 0;
          end
          1: begin
            send_idle_pct = 45;
            stall_pct    <= 0;
          end
          2: begin
            send_idle_pct = 0;
            stall_pct    <= 45;
          end
          default: begin
            send_idle_pct = 26;
            stall_pct    <= 26;
          end
        endcase
      end
      rad = 16'($urandom);
      az  = 16'($urandom);
      el  = 16'($urandom_range(32768) - 16384);
      if ($urandom_range(15) == 0) begin
        rad = $urandom_range(1) ? 16'hffff : 16'h0000;
      end
      if ($urandom_range(7) == 0) begin
        az = 16'($urandom_range(3) << 14);
      end
      if ($urandom_range(7) == 0) begin
        el = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
      end
      send_position(rad, az, el);
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

endmodule
